>>> sv/bhd_pkg.sv
// Shared types, constants and the popcount function for the bit-plane Hamming distance unit.
package bhd_pkg;

  localparam int MAX_WORD_BITS = 64;
  localparam int MAX_PLANES    = 4;
  localparam int POP_W         = $clog2(MAX_WORD_BITS + 1);
  localparam int LIMIT_W       = 10;
  localparam int DIST_W        = 11;
  localparam int PLN_W         = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;
  localparam int QDEPTH        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 10'd2;
  localparam logic               CNT_UNK_RST = 1'b1;
  localparam logic [PLN_W-1:0]   PLANES_RST  = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISTANCE_LIMIT = 2'd0,
    REG_COUNT_UNKNOWN  = 2'd1,
    REG_PLANES_USED    = 2'd2
  } cfg_reg_t;

  // one classified word: per-position mismatch and matched-unknown masks
  typedef struct packed {
    logic [MAX_WORD_BITS-1:0] diff;
    logic [MAX_WORD_BITS-1:0] unk;
    logic                     last;
  } word_cls_t;

  // balanced adder tree, log2(MAX_WORD_BITS) levels deep
  function automatic logic [POP_W-1:0] popcnt(input logic [MAX_WORD_BITS-1:0] v);
    logic [POP_W-1:0] lvl [MAX_WORD_BITS];
    for (int i = 0; i < MAX_WORD_BITS; i++) begin
      lvl[i] = POP_W'(v[i]);
    end
    for (int w = MAX_WORD_BITS >> 1; w >= 1; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        lvl[i] = lvl[2*i] + lvl[2*i+1];
      end
    end
    return lvl[0];
  endfunction

endpackage

>>> sv/bhd_front.sv
// Front end: accepts plane words, builds mismatch/unknown masks, queues them for the back end.
module bhd_front import bhd_pkg::*; #(
  parameter int WORD_BITS = MAX_WORD_BITS,
  parameter int PLANES    = MAX_PLANES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MAX_WORD_BITS-1:0] a_plane [MAX_PLANES],
  input  logic [MAX_WORD_BITS-1:0] b_plane [MAX_PLANES],
  input  logic                     last_word,
  input  logic [PLN_W-1:0]         planes_used,
  output logic                     q_valid,
  output word_cls_t                q_data,
  input  logic                     q_pop
);

  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [MAX_WORD_BITS-1:0] WORD_MASK = {MAX_WORD_BITS{1'b1}} >>
                                                   (MAX_WORD_BITS - WORD_BITS);

  word_cls_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PLN_W-1:0]  np;
  word_cls_t         cls;
  logic              push;

  // plane count clamped to 1..PLANES
  always_comb begin
    if (planes_used == '0) begin
      np = PLN_W'(1);
    end else if (planes_used > PLN_W'(PLANES)) begin
      np = PLN_W'(PLANES);
    end else begin
      np = planes_used;
    end
  end

  always_comb begin
    cls.diff = '0;
    cls.unk  = WORD_MASK;
    cls.last = last_word;
    for (int p = 0; p < PLANES; p++) begin
      if (PLN_W'(p) < np) begin
        cls.diff = cls.diff | ((a_plane[p] ^ b_plane[p]) & WORD_MASK);
        cls.unk  = cls.unk & a_plane[p] & b_plane[p];
      end
    end
  end

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

>>> sv/bhd_back.sv
// Back end: popcounts queued masks, keeps the saturating count, registers the result.
module bhd_back import bhd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  word_cls_t          q_data,
  output logic               q_pop,
  input  logic [LIMIT_W-1:0] distance_limit,
  input  logic               count_unknown,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DIST_W-1:0]  out_distance,
  output logic               out_within_limit
);

  localparam int SUM_W = DIST_W + 1;

  logic [DIST_W-1:0] run_r, run_nxt;
  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r;
  logic              within_r;
  logic [DIST_W-1:0] sat;
  logic [SUM_W-1:0]  sum;
  logic [POP_W-1:0]  pc_diff;
  logic [POP_W-1:0]  pc_unk;

  assign q_pop   = q_valid && (!out_valid_r || out_ready);
  assign sat     = DIST_W'(distance_limit) + 1'b1;
  assign pc_diff = popcnt(q_data.diff);
  assign pc_unk  = count_unknown ? popcnt(q_data.unk) : '0;

  always_comb begin
    sum = SUM_W'(run_r) + SUM_W'(pc_diff) + SUM_W'(pc_unk);
    if (sum > SUM_W'(sat)) begin
      run_nxt = sat;
    end else begin
      run_nxt = sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_data.last) begin
          run_r       <= '0;
          out_valid_r <= 1'b1;
        end else begin
          run_r <= run_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      dist_r   <= run_nxt;
      within_r <= (run_nxt <= DIST_W'(distance_limit));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance     = dist_r;
  assign out_within_limit = within_r;

endmodule

>>> sv/bitplane_hamming_distance_unit.sv
// Top level of the bit-plane Hamming distance unit: config registers, front and back ends.
// Usage:
//   Input channel (in_valid/in_ready): one word per transfer holding WORD_BITS positions
//   of every plane of sequences A and B, plus in_last_word on the final word of a pair.
//   Output channel (out_valid/out_ready): one result per pair, out_distance saturated at
//   distance_limit + 1, and out_within_limit.
//   Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects distance_limit,
//   count_unknown or planes_used; write only while no pair is in flight.
// Timing:
//   Throughput is one word per cycle while no result waits on out_ready, set by the
//   combinational popcount and registered accumulate in the back end. A pair's last word
//   is written to the queue, popped into the back end, and its result registered there.
// Reset:
//   Synchronous active-low rst_n clears the queue, the running count and the output
//   valid flag, and loads limit 2, count_unknown 1, planes_used 2.
// Stalls:
//   While out_ready is low with a result held, the back end stops popping; the queue
//   fills and in_ready drops once both entries are taken.
module bitplane_hamming_distance_unit import bhd_pkg::*; #(
  parameter int WORD_BITS = MAX_WORD_BITS,
  parameter int PLANES    = MAX_PLANES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane0,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane1,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane2,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane3,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane0,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane1,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane2,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane3,
  input  logic                     in_last_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DIST_W-1:0]        out_distance,
  output logic                     out_within_limit,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  logic [LIMIT_W-1:0]       limit_r;
  logic                     cnt_unk_r;
  logic [PLN_W-1:0]         planes_r;
  logic [MAX_WORD_BITS-1:0] a_plane [MAX_PLANES];
  logic [MAX_WORD_BITS-1:0] b_plane [MAX_PLANES];
  logic                     q_valid;
  logic                     q_pop;
  word_cls_t                q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LIMIT_RST;
      cnt_unk_r <= CNT_UNK_RST;
      planes_r  <= PLANES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DISTANCE_LIMIT: limit_r   <= cfg_data[LIMIT_W-1:0];
        REG_COUNT_UNKNOWN:  cnt_unk_r <= cfg_data[0];
        REG_PLANES_USED:    planes_r  <= cfg_data[PLN_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_plane[0] = in_a_plane0;
  assign a_plane[1] = in_a_plane1;
  assign a_plane[2] = in_a_plane2;
  assign a_plane[3] = in_a_plane3;
  assign b_plane[0] = in_b_plane0;
  assign b_plane[1] = in_b_plane1;
  assign b_plane[2] = in_b_plane2;
  assign b_plane[3] = in_b_plane3;

  bhd_front #(
    .WORD_BITS (WORD_BITS),
    .PLANES    (PLANES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .a_plane     (a_plane),
    .b_plane     (b_plane),
    .last_word   (in_last_word),
    .planes_used (planes_r),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  bhd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .distance_limit   (limit_r),
    .count_unknown    (cnt_unk_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_distance     (out_distance),
    .out_within_limit (out_within_limit)
  );

endmodule

>>> test/bhd_distance_checker.sv
// Checker for the bit-plane Hamming distance unit: tracks config, predicts and compares results.
`timescale 1ns / 100ps

module bhd_distance_checker import bhd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane0,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane1,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane2,
  input  logic [MAX_WORD_BITS-1:0] in_a_plane3,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane0,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane1,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane2,
  input  logic [MAX_WORD_BITS-1:0] in_b_plane3,
  input  logic                     in_last_word,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [DIST_W-1:0]        out_distance,
  input  logic                     out_within_limit,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       words_seen,
  output int                       pairs_seen
);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              similar;
  } pair_result_t;

  pair_result_t              pair_results_q[$];
  logic [LIMIT_W-1:0]        limit_r;
  logic                      count_unk_r;
  logic [PLN_W-1:0]          planes_r;
  logic [DIST_W-1:0]         tally;
  int                        fails;
  int                        words;
  int                        pairs;

  // adds one word's mismatches (and matched unknowns) to the count, saturating at limit + 1
  function automatic logic [DIST_W-1:0] fold_word(
    input logic [DIST_W-1:0]                    prior,
    input logic [MAX_PLANES-1:0][MAX_WORD_BITS-1:0] a,
    input logic [MAX_PLANES-1:0][MAX_WORD_BITS-1:0] b,
    input logic [LIMIT_W-1:0]                   lim,
    input logic                                 cu,
    input logic [PLN_W-1:0]                     planes
  );
    int                       np;
    int                       sum;
    logic [MAX_WORD_BITS-1:0] diff;
    logic [MAX_WORD_BITS-1:0] both_unk;
    np = (planes == 0) ? 1 : (planes > MAX_PLANES) ? MAX_PLANES : int'(planes);
    diff = '0;
    both_unk = '1;
    for (int p = 0; p < MAX_PLANES; p++) begin
      if (p < np) begin
        diff |= a[p] ^ b[p];
        both_unk &= a[p] & b[p];
      end
    end
    sum = int'(prior) + $countones(diff);
    if (cu) sum += $countones(both_unk);
    if (sum > int'(lim) + 1) sum = int'(lim) + 1;
    return DIST_W'(sum);
  endfunction

  always @(posedge clk) begin
    pair_result_t want;
    if (!rst_n) begin
      limit_r = LIMIT_RST;
      count_unk_r = CNT_UNK_RST;
      planes_r = PLANES_RST;
      tally = '0;
      fails = 0;
      words = 0;
      pairs = 0;
      pair_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DISTANCE_LIMIT: limit_r = cfg_data[LIMIT_W-1:0];
          REG_COUNT_UNKNOWN:  count_unk_r = cfg_data[0];
          REG_PLANES_USED:    planes_r = cfg_data[PLN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        tally = fold_word(tally,
                          {in_a_plane3, in_a_plane2, in_a_plane1, in_a_plane0},
                          {in_b_plane3, in_b_plane2, in_b_plane1, in_b_plane0},
                          limit_r, count_unk_r, planes_r);
        words++;
        if (in_last_word) begin
          want.distance = tally;
          want.similar  = (tally <= DIST_W'(limit_r));
          pair_results_q.insert(pair_results_q.size(), want);
          tally = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (pair_results_q.size() == 0) begin
          $error("out_distance: no result expected, got %0d", out_distance);
          fails++;
        end else begin
          want = pair_results_q.pop_front();
          pairs++;
          if (out_distance !== want.distance) begin
            $error("out_distance: expected %0d, got %0d", want.distance, out_distance);
            fails++;
          end
          if (out_within_limit !== want.similar) begin
            $error("out_within_limit: expected %0d, got %0d", want.similar, out_within_limit);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending <= pair_results_q.size();
    words_seen <= words;
    pairs_seen <= pairs;
  end

endmodule

>>> test/bitplane_hamming_distance_unit_tb.sv
// Testbench top for the bit-plane Hamming distance unit: stimulus, config phases and verdict.
`timescale 1ns / 100ps

module bitplane_hamming_distance_unit_tb;
  import bhd_pkg::*;

  localparam logic [CFG_IDX_W-1:0]     REG_SPARE = 2'd3;  // no register behind this index
  localparam logic [MAX_WORD_BITS-1:0] ONES = '1;
  localparam logic [MAX_WORD_BITS-1:0] ZERO = '0;
  localparam int                       RANDOM_WORDS = 1500;

  typedef logic [MAX_PLANES-1:0][MAX_WORD_BITS-1:0] planes_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [MAX_WORD_BITS-1:0] in_a_plane0 = '0;
  logic [MAX_WORD_BITS-1:0] in_a_plane1 = '0;
  logic [MAX_WORD_BITS-1:0] in_a_plane2 = '0;
  logic [MAX_WORD_BITS-1:0] in_a_plane3 = '0;
  logic [MAX_WORD_BITS-1:0] in_b_plane0 = '0;
  logic [MAX_WORD_BITS-1:0] in_b_plane1 = '0;
  logic [MAX_WORD_BITS-1:0] in_b_plane2 = '0;
  logic [MAX_WORD_BITS-1:0] in_b_plane3 = '0;
  logic                     in_last_word = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DIST_W-1:0]        out_distance;
  logic                     out_within_limit;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int   fail_count;
  int   pending;
  int   words_seen;
  int   pairs_seen;
  logic calm = 1'b0;     // no idling on either side while set
  int   settings = 1;
  int   out_hold;

  bitplane_hamming_distance_unit dut (.*);

  bhd_distance_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("bitplane_hamming_distance_unit test failed");
    $finish;
  end

  // result side: stall a random number of cycles after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_hold = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_hold = calm ? 0 : $urandom_range(0, 18);
      else if (out_hold > 0) out_hold--;
      out_ready <= (out_hold == 0);
    end
  end

  task automatic send_word(input planes_t a, input planes_t b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_a_plane0 <= a[0];
    in_a_plane1 <= a[1];
    in_a_plane2 <= a[2];
    in_a_plane3 <= a[3];
    in_b_plane0 <= b[0];
    in_b_plane1 <= b[1];
    in_b_plane2 <= b[2];
    in_b_plane3 <= b[3];
    in_last_word <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // caller lowers cfg_valid after a group of writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait until every pair result is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [LIMIT_W-1:0] lim, input logic cu,
                            input logic [PLN_W-1:0] planes);
    settle();
    write_reg(REG_DISTANCE_LIMIT, lim);
    write_reg(REG_COUNT_UNKNOWN, {9'($urandom), cu});
    write_reg(REG_PLANES_USED, {7'($urandom), planes});
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [MAX_WORD_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void make_word(output planes_t a, output planes_t b);
    logic [MAX_WORD_BITS-1:0] flips;
    logic [MAX_WORD_BITS-1:0] unk;
    int                       kind;
    kind = $urandom_range(0, 9);
    flips = $urandom_range(0, 1) ? (64'd1 << $urandom_range(0, 63))
                                 : rand64() & rand64() & rand64() & rand64();
    unk = rand64() & rand64();
    for (int p = 0; p < MAX_PLANES; p++) begin
      a[p] = rand64();
      b[p] = rand64();
    end
    case (kind)
      0, 1: ;
      2, 3, 4, 5: begin
        b = a;
        b[$urandom_range(0, 3)] ^= flips;
      end
      6, 7, 8: begin
        for (int p = 0; p < MAX_PLANES; p++) a[p] |= unk;
        b = a;
        if (kind == 8) b[$urandom_range(0, 3)] ^= flips;
      end
      default: begin
        for (int p = 0; p < MAX_PLANES; p++) begin
          a[p] = $urandom_range(0, 1) ? ONES : ZERO;
          b[p] = $urandom_range(0, 1) ? ONES : ZERO;
        end
      end
    endcase
  endfunction

  initial begin
    planes_t                a;
    planes_t                b;
    int                     sent;
    int                     phase_words;
    int                     pair_len;
    logic [LIMIT_W-1:0]     lim;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: limit 2, unknowns counted, two planes
    send_word({4{ZERO}}, {4{ZERO}}, 1'b1);
    send_word({4{ONES}}, {4{ONES}}, 1'b1);
    send_word({ZERO, ZERO, ZERO, 64'h1}, {4{ZERO}}, 1'b0);
    send_word({ZERO, ZERO, 64'h8000_0000_0000_0000, ZERO}, {4{ZERO}}, 1'b1);
    send_word({ONES, ONES, ZERO, ZERO}, {4{ZERO}}, 1'b1);   // only unused planes differ
    send_word({ZERO, ZERO, ONES, ONES}, {ZERO, ONES, ONES, ONES}, 1'b1);

    // widest limit, unknowns off through a data word with high bits set
    settle();
    write_reg(REG_DISTANCE_LIMIT, 10'd1023);
    write_reg(REG_COUNT_UNKNOWN, 10'h3FE);
    write_reg(REG_PLANES_USED, 10'd4);
    write_reg(REG_SPARE, 10'h3FF);
    cfg_valid <= 1'b0;
    settings++;
    send_word({4{ONES}}, {4{ONES}}, 1'b1);
    // pair with more mismatches than the limit: count saturates at limit + 1
    for (int i = 0; i < 17; i++) send_word({4{ONES}}, {4{ZERO}}, i == 16);

    // zero planes acts as one plane, limit zero
    set_config(10'd0, 1'b1, 3'd0);
    send_word({ZERO, ZERO, ONES, ZERO}, {4{ZERO}}, 1'b1);
    send_word({ZERO, ZERO, ZERO, ZERO}, {ZERO, ZERO, ZERO, ZERO}, 1'b1);
    send_word({ZERO, ZERO, ZERO, 64'h5}, {ZERO, ZERO, ONES, 64'h5}, 1'b1);

    // plane count above four acts as four
    set_config(10'd1023, 1'b1, 3'd7);
    send_word({64'h1, ZERO, ZERO, ZERO}, {4{ZERO}}, 1'b1);
    send_word({64'hAAAA_AAAA_AAAA_AAAA, ZERO, 64'h5555_5555_5555_5555, ZERO},
              {64'h5555_5555_5555_5555, ZERO, 64'h5555_5555_5555_5555, ZERO}, 1'b1);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 5))
        0: lim = 10'd0;
        1: lim = 10'd1023;
        2: lim = LIMIT_RST;
        3: lim = LIMIT_W'($urandom_range(1, 40));
        4: lim = LIMIT_W'($urandom_range(41, 300));
        default: lim = LIMIT_W'($urandom_range(0, 1023));
      endcase
      set_config(lim, 1'($urandom), 3'($urandom));
      calm = ($urandom_range(0, 3) == 0);
      phase_words = 0;
      while (phase_words < 125) begin
        pair_len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        for (int i = 0; i < pair_len; i++) begin
          make_word(a, b);
          send_word(a, b, i == pair_len - 1);
        end
        phase_words += pair_len;
      end
      sent += phase_words;
    end

    settle();
    calm = 1'b0;
    $display("%0d words in %0d sequence pairs checked over %0d register settings",
             words_seen, pairs_seen, settings);
    $display("limits from 0 to 1023, plane counts 0 to 7, unknown counting on and off");
    if (fail_count == 0) begin
      $display("bitplane_hamming_distance_unit test passed");
    end else begin
      $display("bitplane_hamming_distance_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/bhd_pkg.sv
sv/bhd_front.sv
sv/bhd_back.sv
sv/bitplane_hamming_distance_unit.sv
test/bhd_distance_checker.sv
test/bitplane_hamming_distance_unit_tb.sv
